/* rtl/as5_pkg.sv */
package as5_pkg;

    // Window geometry: spans the longest definition, flushed after the last byte
    localparam int WinLen     = 30;
    localparam int FlushSteps = 28;

    // AML opcodes and prefixes
    localparam logic [7:0] OpName  = 8'h08;
    localparam logic [7:0] OpRoot  = 8'h5C;
    localparam logic [7:0] OpPkg   = 8'h12;
    localparam logic [7:0] OpZero  = 8'h00;
    localparam logic [7:0] OpOne   = 8'h01;
    localparam logic [7:0] OpOnes  = 8'hFF;
    localparam logic [7:0] OpByte  = 8'h0A;
    localparam logic [7:0] OpWord  = 8'h0B;
    localparam logic [7:0] OpDword = 8'h0C;
    localparam logic [7:0] OpQword = 8'h0E;

    // Name characters of _S5_
    localparam logic [7:0] ChUnder = 8'h5F;
    localparam logic [7:0] ChS     = 8'h53;
    localparam logic [7:0] Ch5     = 8'h35;

    typedef struct packed {
        logic [7:0] aml_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic       found;
        logic [2:0] slp_typ_a;
        logic [2:0] slp_typ_b;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_FINISH
    } scan_state_t;

endpackage

/* rtl/as5_fifo.sv */
module as5_fifo #(
    parameter int Depth = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  as5_pkg::in_item_t  din,
    output logic               full,
    input  logic               pop,
    output as5_pkg::in_item_t  dout,
    output logic               empty
);
    import as5_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    in_item_t            mem [Depth];
    logic     [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic     [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic     [CntW-1:0] cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full    = (cnt_reg == CntW'(Depth));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Item storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

/* rtl/as5_scan.sv */
module as5_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  as5_pkg::in_item_t  in_item,
    output logic               in_take,
    output logic               res_valid,
    output as5_pkg::out_item_t res_item,
    input  logic               res_ready
);
    import as5_pkg::*;

    typedef struct packed {
        logic       ok;
        logic [3:0] size;
        logic       fits;
        logic [2:0] val;
    } const_t;

    // Decode one integer constant; room is the byte count left before the limit
    function automatic const_t dec_const(input logic [71:0] b, input logic [4:0] room);
        const_t r;
        r = '0;
        case (b[7:0])
            OpZero:
            begin
                r.ok = 1'b1; r.size = 4'd1; r.fits = 1'b1; r.val = 3'd0;
            end
            OpOne:
            begin
                r.ok = 1'b1; r.size = 4'd1; r.fits = 1'b1; r.val = 3'd1;
            end
            OpOnes:
            begin
                r.ok = 1'b1; r.size = 4'd1; r.fits = 1'b0;
            end
            OpByte:
            begin
                r.ok    = (room >= 5'd2);
                r.size  = 4'd2;
                r.fits  = (b[15:11] == '0);
                r.val   = b[10:8];
            end
            OpWord:
            begin
                r.ok    = (room >= 5'd3);
                r.size  = 4'd3;
                r.fits  = (b[15:11] == '0) && (b[23:16] == '0);
                r.val   = b[10:8];
            end
            OpDword:
            begin
                r.ok    = (room >= 5'd5);
                r.size  = 4'd5;
                r.fits  = (b[15:11] == '0) && (b[39:16] == '0);
                r.val   = b[10:8];
            end
            OpQword:
            begin
                r.ok    = (room >= 5'd9);
                r.size  = 4'd9;
                r.fits  = (b[15:11] == '0) && (b[71:16] == '0);
                r.val   = b[10:8];
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    scan_state_t        state_reg, state_next;
    logic         [7:0] win_reg [WinLen];
    logic  [WinLen-1:0] vld_reg;
    logic         [4:0] lim_reg, lim_next;
    logic         [4:0] cnt_reg, cnt_next;
    logic               chk_reg, chk_next;
    logic               match_reg;
    logic         [2:0] typ_a_reg, typ_b_reg;

    logic               shift, shift_vld, clear;
    logic         [7:0] shift_byte;

    // Candidate check signals
    logic               name_ok, def_ok, pkg_ok, len_ok, body_ok, a_ok, b_use, cand, hit;
    logic         [7:0] b0, nelem;
    logic         [1:0] follow;
    logic        [27:0] pkglen;
    logic               big;
    logic         [5:0] pe_sum;
    logic         [4:0] pe, qn, qa, qb;
    logic        [71:0] ga, gb;
    const_t             ca, cb;
    logic               b_small;
    logic         [2:0] b_val;

    // Check of the definition whose name starts at window index 2
    always_comb
    begin
        name_ok = vld_reg[2] && (lim_reg >= 5'd6) && (win_reg[2] == ChUnder) &&
                  (win_reg[3] == ChS) && (win_reg[4] == Ch5) && (win_reg[5] == ChUnder);
        def_ok  = vld_reg[1] && ((win_reg[1] == OpName) ||
                  (vld_reg[0] && (win_reg[1] == OpRoot) && (win_reg[0] == OpName)));
        pkg_ok  = (lim_reg >= 5'd8) && (win_reg[6] == OpPkg);

        // Package length, counting itself, clamped to the table end
        b0     = win_reg[7];
        follow = b0[7:6];
        len_ok = ((lim_reg - 5'd7) >= (5'd1 + {3'b000, follow}));
        if (follow == 2'd0)
        begin
            pkglen = {22'd0, b0[5:0]};
        end
        else
        begin
            pkglen = {(follow == 2'd3) ? win_reg[10] : 8'd0,
                      (follow >= 2'd2) ? win_reg[9]  : 8'd0,
                      win_reg[8], b0[3:0]};
        end
        big    = |pkglen[27:5];
        pe_sum = 6'd7 + {1'b0, pkglen[4:0]};
        pe     = (big || (pe_sum > {1'b0, lim_reg})) ? lim_reg : pe_sum[4:0];

        // Element count and first constant
        qn      = 5'd8 + {3'b000, follow};
        body_ok = (qn < pe);
        nelem   = win_reg[qn];
        qa      = qn + 5'd1;
        for (int k = 0; k < 9; k++)
        begin
            ga[8*k +: 8] = win_reg[qa + 5'(k)];
        end
        ca   = (qa < pe) ? dec_const(ga, pe - qa) : '0;
        a_ok = (nelem != 8'd0) && ca.ok;

        // Second constant, or a copy of the first
        qb = qa + {1'b0, ca.size};
        for (int k = 0; k < 9; k++)
        begin
            gb[8*k +: 8] = win_reg[qb + 5'(k)];
        end
        cb      = (qb < pe) ? dec_const(gb, pe - qb) : '0;
        b_use   = (nelem >= 8'd2) && cb.ok;
        b_small = b_use ? cb.fits : ca.fits;
        b_val   = b_use ? cb.val : ca.val;

        cand = name_ok && def_ok && pkg_ok && len_ok && body_ok && a_ok && ca.fits && b_small;
        hit  = chk_reg && !match_reg && cand;
    end

    // Sequencer: run, flush the window, then hand over the verdict
    always_comb
    begin
        state_next = state_reg;
        lim_next   = lim_reg;
        cnt_next   = cnt_reg;
        chk_next   = 1'b0;
        in_take    = 1'b0;
        res_valid  = 1'b0;
        shift      = 1'b0;
        shift_vld  = 1'b0;
        shift_byte = 8'd0;
        clear      = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                in_take = in_valid;
                if (in_valid)
                begin
                    shift      = 1'b1;
                    shift_vld  = 1'b1;
                    shift_byte = in_item.aml_byte;
                    lim_next   = 5'(WinLen);
                    chk_next   = 1'b1;
                    if (in_item.last_byte)
                    begin
                        cnt_next   = '0;
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                shift    = 1'b1;
                lim_next = lim_reg - 5'd1;
                chk_next = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(FlushSteps - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold the verdict back while the check of the final window is still pending
                res_valid = !chk_reg;
                if (res_valid && res_ready)
                begin
                    clear      = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    assign res_item.found     = match_reg;
    assign res_item.slp_typ_a = typ_a_reg;
    assign res_item.slp_typ_b = typ_b_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            lim_reg   <= '0;
            cnt_reg   <= '0;
            chk_reg   <= 1'b0;
            vld_reg   <= '0;
            match_reg <= 1'b0;
            typ_a_reg <= '0;
            typ_b_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lim_reg   <= lim_next;
            cnt_reg   <= cnt_next;
            chk_reg   <= chk_next;
            if (clear)
            begin
                vld_reg   <= '0;
                match_reg <= 1'b0;
                typ_a_reg <= '0;
                typ_b_reg <= '0;
            end
            else
            begin
                if (shift)
                begin
                    vld_reg <= {shift_vld, vld_reg[WinLen-1:1]};
                end
                if (hit)
                begin
                    match_reg <= 1'b1;
                    typ_a_reg <= ca.val;
                    typ_b_reg <= b_val;
                end
            end
        end
    end

    // Byte window, newest at the top
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            for (int i = 0; i < WinLen - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WinLen-1] <= shift_byte;
        end
    end

endmodule

/* rtl/aml_s5_sleep_type_finder_core.sv */
// Channel | Ports              | Handshake                        | Item
// --------+--------------------+----------------------------------+---------------------------
// input   | push, full, item   | taken when push && !full         | aml_byte, last_byte
// result  | pop, empty, result | taken when pop && !empty         | found, slp_typ_a, slp_typ_b
//
// Table bytes are scanned at one per cycle through the 30-byte window, but none are
// taken during the flush or while the verdict waits. The byte marked last starts the
// window flush, then the final check; the verdict then lands in the result register.
// Input items keep queuing in the front queue during the flush until it is full.
// Reset (rst_n low, asynchronous) empties both queues and clears the window state.
module aml_s5_sleep_type_finder_core #(
    parameter int QueueDepth = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  as5_pkg::in_item_t  item,
    output logic               full,
    input  logic               pop,
    output as5_pkg::out_item_t result,
    output logic               empty
);
    import as5_pkg::*;

    in_item_t  q_item;
    logic      q_empty, q_take;
    logic      res_valid, res_ready;
    out_item_t res_item;
    out_item_t out_reg;
    logic      out_vld_reg;

    // Front: queue of accepted bytes
    as5_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (item),
        .full  (full),
        .pop   (q_take),
        .dout  (q_item),
        .empty (q_empty)
    );

    // Back: window scan and verdict
    as5_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!q_empty),
        .in_item   (q_item),
        .in_take   (q_take),
        .res_valid (res_valid),
        .res_item  (res_item),
        .res_ready (res_ready)
    );

    // Result register
    assign res_ready = !out_vld_reg || pop;
    assign empty     = !out_vld_reg;
    assign result    = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res_item;
        end
    end

endmodule

/* verif/tb_aml_s5_sleep_type_finder_core.sv */
`timescale 1ns / 1ps

module tb_aml_s5_sleep_type_finder_core;
    import as5_pkg::*;

    localparam int PhaseItems  = 330;
    localparam int LongHold    = 600;
    localparam int DrainCycles = 100;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    in_item_t  item  = '0;
    logic      full;
    logic      pop   = 1'b0;
    out_item_t result;
    logic      empty;

    aml_s5_sleep_type_finder_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .pop    (pop),
        .result (result),
        .empty  (empty)
    );

    always #1 clk = ~clk;

    // Byte items waiting to be offered, and verdicts waiting to come out
    in_item_t  byte_backlog[$];
    out_item_t pending_verdicts[$];
    out_item_t next_verdict;
    out_item_t oldest_verdict;

    // Scratch space for building one table body
    logic [7:0] tbl_bytes[$];
    logic [7:0] pkg_body[$];
    int         gen_count = 0;

    // Idle rates in percent, long receiver hold-off
    int   send_idle = 0;
    int   recv_idle = 0;
    logic hold_kick = 1'b0;
    int   hold_cycles;
    logic recv_hold;
    int   error_count = 0;

    // Scanner state mirrored for prediction
    logic [7:0] win_b [WinLen];
    logic       win_v [WinLen];
    logic       s5_hit = 1'b0;
    logic [2:0] hit_a  = '0;
    logic [2:0] hit_b  = '0;

    initial
    begin
        for (int i = 0; i < WinLen; i++)
        begin
            win_b[i] = '0;
            win_v[i] = 1'b0;
        end
    end

    task automatic flag_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    function automatic void slide_in(logic [7:0] b, logic v);
        for (int i = 0; i < WinLen - 1; i++)
        begin
            win_b[i] = win_b[i + 1];
            win_v[i] = win_v[i + 1];
        end
        win_b[WinLen - 1] = b;
        win_v[WinLen - 1] = v;
    endfunction

    function automatic logic [31:0] le_word(int unsigned at, int unsigned n);
        logic [31:0] v;
        v = '0;
        for (int unsigned i = 0; i < n; i++)
            v |= 32'(win_b[at + i]) << (8 * i);
        return v;
    endfunction

    // Integer constant at window index at, bounded by lim; size in bytes, 0 if invalid
    function automatic int unsigned decode_const(int unsigned at, int unsigned lim,
                                                 output logic [63:0] val);
        val = '0;
        if (at >= lim)
            return 0;
        case (win_b[at])
            OpZero: return 1;
            OpOne:
            begin
                val = 64'd1;
                return 1;
            end
            OpOnes:
            begin
                val = '1;
                return 1;
            end
            OpByte:
            begin
                if (lim - at < 2) return 0;
                val = 64'(win_b[at + 1]);
                return 2;
            end
            OpWord:
            begin
                if (lim - at < 3) return 0;
                val = 64'(le_word(at + 1, 2));
                return 3;
            end
            OpDword:
            begin
                if (lim - at < 5) return 0;
                val = 64'(le_word(at + 1, 4));
                return 5;
            end
            OpQword:
            begin
                if (lim - at < 9) return 0;
                val = {le_word(at + 5, 4), le_word(at + 1, 4)};
                return 9;
            end
            default: return 0;
        endcase
    endfunction

    // Looks for a definition whose name sits at window index 2
    function automatic void check_window();
        int unsigned avail, e, q, follow, c, pkglen, pe;
        logic [7:0]  b0, nelem;
        logic [63:0] va, vb;
        logic        named;
        if (s5_hit)
            return;
        avail = 0;
        while (2 + avail < WinLen && win_v[2 + avail])
            avail++;
        if (avail < 4)
            return;
        e = 2 + avail;
        if (win_b[2] != ChUnder || win_b[3] != ChS || win_b[4] != Ch5 || win_b[5] != ChUnder)
            return;
        named = (win_v[1] && win_b[1] == OpName) ||
                (win_v[1] && win_v[0] && win_b[1] == OpRoot && win_b[0] == OpName);
        if (!named)
            return;
        if (6 >= e || win_b[6] != OpPkg)
            return;
        q = 7;
        if (q >= e)
            return;
        b0 = win_b[q];
        follow = b0[7:6];
        if (e - q < 1 + follow)
            return;
        if (follow == 0)
            pkglen = b0[5:0];
        else
        begin
            pkglen = b0[3:0];
            for (int unsigned i = 0; i < follow; i++)
                pkglen |= 32'(win_b[q + 1 + i]) << (4 + 8 * i);
        end
        // package end clamps to the table end
        pe = q + pkglen;
        if (pe > e)
            pe = e;
        q += 1 + follow;
        if (q >= pe)
            return;
        nelem = win_b[q];
        q++;
        c = decode_const(q, pe, va);
        if (nelem < 1 || c == 0)
            return;
        q += c;
        if (nelem < 2 || decode_const(q, pe, vb) == 0)
            vb = va;
        if (va > 7 || vb > 7)
            return;
        s5_hit = 1'b1;
        hit_a  = va[2:0];
        hit_b  = vb[2:0];
    endfunction

    // One accepted byte; returns 1 with the verdict when it closes the table
    function automatic logic scan_aml_byte(in_item_t it, output out_item_t verdict);
        verdict = '0;
        slide_in(it.aml_byte, 1'b1);
        check_window();
        if (!it.last_byte)
            return 1'b0;
        for (int i = 0; i < FlushSteps; i++)
        begin
            slide_in(8'h00, 1'b0);
            check_window();
        end
        verdict.found     = s5_hit;
        verdict.slp_typ_a = s5_hit ? hit_a : 3'd0;
        verdict.slp_typ_b = s5_hit ? hit_b : 3'd0;
        for (int i = 0; i < WinLen; i++)
        begin
            win_b[i] = '0;
            win_v[i] = 1'b0;
        end
        s5_hit = 1'b0;
        hit_a  = '0;
        hit_b  = '0;
        return 1'b1;
    endfunction

    // Driver: predicts on accept, then offers the next byte or idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                if (scan_aml_byte(item, next_verdict))
                    pending_verdicts.push_back(next_verdict);
                void'(byte_backlog.pop_front());
            end
            // a stalled item stays on the port
            if (!(push && full))
            begin
                if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    push <= 1'b1;
                    item <= byte_backlog[0];
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here
    assign recv_hold = hold_kick && hold_cycles < LongHold;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cycles <= 0;
        else if (recv_hold)
            hold_cycles <= hold_cycles + 1;
    end

    // Monitor: compares each popped result with the oldest verdict
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (pending_verdicts.size() == 0)
                    flag_mismatch("unexpected result (found)", result.found, -1);
                else
                begin
                    oldest_verdict = pending_verdicts.pop_front();
                    if (result.found !== oldest_verdict.found)
                        flag_mismatch("found", result.found, oldest_verdict.found);
                    if (result.slp_typ_a !== oldest_verdict.slp_typ_a)
                        flag_mismatch("slp_typ_a", result.slp_typ_a, oldest_verdict.slp_typ_a);
                    if (result.slp_typ_b !== oldest_verdict.slp_typ_b)
                        flag_mismatch("slp_typ_b", result.slp_typ_b, oldest_verdict.slp_typ_b);
                end
            end
            pop <= !recv_hold && ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Move the table under construction into the backlog, last byte marked
    task automatic ship_table();
        for (int i = 0; i < tbl_bytes.size(); i++)
            byte_backlog.push_back(in_item_t'{tbl_bytes[i], (i == tbl_bytes.size() - 1)});
        gen_count += tbl_bytes.size();
        tbl_bytes.delete();
    endtask

    function automatic logic [7:0] upper_byte();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
    endfunction

    // Integer constant in a random encoding, values mostly in the accepted range
    task automatic put_const();
        int         pick;
        logic [7:0] low;
        pick = $urandom_range(0, 9);
        low  = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
        case (pick)
            0: pkg_body.push_back(OpZero);
            1: pkg_body.push_back(OpOne);
            2: pkg_body.push_back(OpOnes);
            3, 4:
            begin
                pkg_body.push_back(OpByte);
                pkg_body.push_back(low);
            end
            5:
            begin
                pkg_body.push_back(OpWord);
                pkg_body.push_back(low);
                pkg_body.push_back(upper_byte());
            end
            6:
            begin
                pkg_body.push_back(OpDword);
                pkg_body.push_back(low);
                repeat (3) pkg_body.push_back(upper_byte());
            end
            7:
            begin
                pkg_body.push_back(OpQword);
                pkg_body.push_back(low);
                repeat (7) pkg_body.push_back(upper_byte());
            end
            default: pkg_body.push_back(8'($urandom));
        endcase
    endtask

    // Name definition with a package, now and then damaged
    task automatic put_definition();
        int unsigned len, follow;
        int          r;
        logic [7:0]  nelem;
        pkg_body.delete();
        r = $urandom_range(0, 9);
        nelem = (r == 0) ? 8'h00 : (r == 1) ? 8'($urandom) : (r < 6) ? 8'h02 : 8'h01;
        pkg_body.push_back(nelem);
        put_const();
        if (nelem >= 2 && $urandom_range(0, 5) != 0)
            put_const();
        follow = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        len = pkg_body.size() + 1 + follow;
        if ($urandom_range(0, 7) == 0)
            len = (follow != 0 && $urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, len + 4);

        tbl_bytes.push_back(($urandom_range(0, 11) == 0) ? 8'($urandom) : OpName);
        if ($urandom_range(0, 1) == 0)
            tbl_bytes.push_back(OpRoot);
        tbl_bytes.push_back(ChUnder);
        tbl_bytes.push_back(ChS);
        tbl_bytes.push_back(Ch5);
        tbl_bytes.push_back(ChUnder);
        if ($urandom_range(0, 11) == 0)
            tbl_bytes[tbl_bytes.size() - 1 - $urandom_range(0, 3)] = 8'($urandom);
        tbl_bytes.push_back(($urandom_range(0, 11) == 0) ? 8'($urandom) : OpPkg);

        // PkgLength: one byte up to 63, else lead byte plus follow bytes
        if (follow == 0)
            tbl_bytes.push_back({2'b00, len[5:0]});
        else
        begin
            tbl_bytes.push_back({follow[1:0], 2'b00, len[3:0]});
            for (int unsigned i = 0; i < follow; i++)
                tbl_bytes.push_back(8'(len >> (4 + 8 * i)));
        end
        foreach (pkg_body[i])
            tbl_bytes.push_back(pkg_body[i]);
    endtask

    task automatic put_noise(int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 7);
            case (r)
                0: tbl_bytes.push_back(OpName);
                1: tbl_bytes.push_back(ChUnder);
                2: tbl_bytes.push_back(OpPkg);
                default: tbl_bytes.push_back(8'($urandom));
            endcase
        end
    endtask

    // Mostly well-formed tables with random content, some pure noise, some cut short
    task automatic put_table();
        int kind, cut;
        kind = $urandom_range(0, 9);
        put_noise($urandom_range(0, 10));
        if (kind >= 2)
        begin
            put_definition();
            if ($urandom_range(0, 4) == 0)
            begin
                put_noise($urandom_range(0, 3));
                put_definition();
            end
        end
        put_noise($urandom_range(0, 6));
        if (tbl_bytes.size() == 0)
            tbl_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 7) == 0)
        begin
            cut = $urandom_range(1, tbl_bytes.size());
            while (tbl_bytes.size() > cut)
                void'(tbl_bytes.pop_back());
        end
        ship_table();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: one-byte tables, rooted two-element match, one-element copy
        send_idle = 22;
        recv_idle = 84;
        tbl_bytes = '{OpOnes};
        ship_table();
        tbl_bytes = '{OpZero};
        ship_table();
        tbl_bytes = '{OpName, OpRoot, ChUnder, ChS, Ch5, ChUnder, OpPkg, 8'h06, 8'h02,
                      OpByte, 8'h05, OpByte, 8'h07};
        ship_table();
        tbl_bytes = '{OpName, ChUnder, ChS, Ch5, ChUnder, OpPkg, 8'h03, 8'h01, OpZero, 8'h80};
        ship_table();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle = 22;
                    recv_idle = 84;
                end
                1:
                begin
                    send_idle = 84;
                    recv_idle = 22;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                    hold_kick = 1'b1;
                end
            endcase
            while (gen_count < (ph + 1) * PhaseItems)
                put_table();
            // sender pauses until every verdict has come back
            while (byte_backlog.size() != 0 || pending_verdicts.size() != 0)
                @(negedge clk);
        end

        repeat (DrainCycles) @(negedge clk);
        if (error_count == 0)
            $display("tb_aml_s5_sleep_type_finder_core: clean");
        else
            $display("tb_aml_s5_sleep_type_finder_core: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("tb_aml_s5_sleep_type_finder_core: errors");
        $finish;
    end

endmodule
